### src/ccfe_pkg.sv
// shared types, constants and the crc step for the cobs frame encoder
// no dependencies
package ccfe_pkg;

	localparam int MAX_PAYLOAD_DEF = 64;
	localparam int STORE_SLACK     = 8;
	localparam int QUEUE_DEPTH     = 4;

	localparam logic [7:0]  SOF_BYTE   = 8'hB2;
	localparam logic [7:0]  DELIM_BYTE = 8'h00;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'h1021;

	// one decoded byte, or the end of a frame, handed from front to back
	typedef struct packed {
		logic       fin;
		logic       item_end;
		logic [7:0] data;
	} sym_t;

	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

### src/crc_cobs_frame_encoder_core.sv
// top level of the cobs frame encoder with crc-16
// depends on ccfe_pkg, ccfe_front, ccfe_fifo, ccfe_back
//
// Each request carries one payload byte; the first request of a frame also
// carries type and length, and last_in_frame closes the frame. The front end
// holds a request while it produces the decoded bytes for it, one per cycle while
// the queue has room: a payload byte, with start, type, sequence and length before
// it on the first request of a frame, and crc low, crc high and end of frame on
// the last request; full stays high meanwhile. A request that adds no byte, such
// as any request of a refused frame, is taken with no stall. The back end emits
// one wire byte per cycle from the block store while the packer is neither full
// nor flushing, with its single read port setting the drain rate, and packs up to
// four bytes per result; a 4-entry queue sits between the two.
// No clearing pass is needed after reset.
module crc_cobs_frame_encoder_core import ccfe_pkg::*; #(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] frame_type,
	input  logic [6:0] payload_len,
	input  logic [7:0] data_byte,
	input  logic       last_in_frame,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte_a,
	output logic [7:0] out_byte_b,
	output logic [7:0] out_byte_c,
	output logic [7:0] out_byte_d,
	output logic [2:0] byte_count,
	output logic       frame_end
);

	localparam int STORE_DEPTH = MAX_PAYLOAD + STORE_SLACK;

	sym_t f_sym, b_sym;
	logic f_vld, q_full, q_empty, b_pop;

	ccfe_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.frame_type   (frame_type),
		.payload_len  (payload_len),
		.data_byte    (data_byte),
		.last_in_frame(last_in_frame),
		.sym_vld      (f_vld),
		.sym          (f_sym),
		.sym_full     (q_full)
	);

	ccfe_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (f_vld),
		.wr_data(f_sym),
		.q_full (q_full),
		.rd_en  (b_pop),
		.rd_data(b_sym),
		.q_empty(q_empty)
	);

	ccfe_back #(.STORE_DEPTH(STORE_DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.sym_empty (q_empty),
		.sym       (b_sym),
		.sym_pop   (b_pop),
		.empty     (empty),
		.pop       (pop),
		.out_byte_a(out_byte_a),
		.out_byte_b(out_byte_b),
		.out_byte_c(out_byte_c),
		.out_byte_d(out_byte_d),
		.byte_count(byte_count),
		.frame_end (frame_end)
	);

endmodule

### src/ccfe_front.sv
// front end: takes requests, keeps frame state and crc, sequences decoded bytes
// depends on ccfe_pkg
module ccfe_front import ccfe_pkg::*; #(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] frame_type,
	input  logic [6:0] payload_len,
	input  logic [7:0] data_byte,
	input  logic       last_in_frame,
	output logic       sym_vld,
	output sym_t       sym,
	input  logic       sym_full
);

	typedef enum logic [8:0] {
		F_IDLE  = 9'b000000001,
		F_SOF   = 9'b000000010,
		F_TYPE  = 9'b000000100,
		F_SEQ   = 9'b000001000,
		F_LEN   = 9'b000010000,
		F_DATA  = 9'b000100000,
		F_CRCLO = 9'b001000000,
		F_CRCHI = 9'b010000000,
		F_FIN   = 9'b100000000
	} fst_t;

	fst_t        st_q, nxt, first_st;
	logic [7:0]  seq_q, type_q, seqb_q, data_q;
	logic [6:0]  len_q, held_len_q, pay_cnt_q;
	logic [15:0] crc_q;
	logic        in_frame_q, disc_q, dat_q, fin_q;

	logic        accept, adv, start, disc_n, hdr_n, dat_n, fin_n, crc_upd;
	logic [6:0]  hl_n, pc_n;
	logic [7:0]  cur_byte;
	fst_t        after_len;

	assign full   = (st_q != F_IDLE);
	assign accept = push && (st_q == F_IDLE);

	always_comb begin
		start  = !in_frame_q;
		disc_n = start ? (payload_len > 7'(MAX_PAYLOAD)) : disc_q;
		hl_n   = start ? payload_len : held_len_q;
		pc_n   = start ? 7'd0 : pay_cnt_q;
		hdr_n  = start && !disc_n;
		dat_n  = !disc_n && (hl_n != 7'd0) && (pc_n < 7'(MAX_PAYLOAD));
		fin_n  = last_in_frame && !disc_n;
		priority if (hdr_n) begin
			first_st = F_SOF;
		end else if (dat_n) begin
			first_st = F_DATA;
		end else if (fin_n) begin
			first_st = F_CRCLO;
		end else begin
			first_st = F_IDLE;
		end
	end

	always_comb begin
		after_len = dat_q ? F_DATA : (fin_q ? F_CRCLO : F_IDLE);
		cur_byte  = 8'h00;
		crc_upd   = 1'b0;
		nxt       = F_IDLE;
		unique case (st_q)
			F_SOF: begin
				cur_byte = SOF_BYTE;
				nxt      = F_TYPE;
			end
			F_TYPE: begin
				cur_byte = type_q;
				crc_upd  = 1'b1;
				nxt      = F_SEQ;
			end
			F_SEQ: begin
				cur_byte = seqb_q;
				crc_upd  = 1'b1;
				nxt      = F_LEN;
			end
			F_LEN: begin
				cur_byte = {1'b0, len_q};
				crc_upd  = 1'b1;
				nxt      = after_len;
			end
			F_DATA: begin
				cur_byte = data_q;
				crc_upd  = 1'b1;
				nxt      = fin_q ? F_CRCLO : F_IDLE;
			end
			F_CRCLO: begin
				cur_byte = crc_q[7:0];
				nxt      = F_CRCHI;
			end
			F_CRCHI: begin
				cur_byte = crc_q[15:8];
				nxt      = F_FIN;
			end
			F_FIN: begin
				cur_byte = DELIM_BYTE;
				nxt      = F_IDLE;
			end
			default: begin
				nxt = F_IDLE;
			end
		endcase
	end

	assign sym_vld      = (st_q != F_IDLE);
	assign sym.fin      = (st_q == F_FIN);
	assign sym.item_end = (nxt == F_IDLE);
	assign sym.data     = cur_byte;
	assign adv          = sym_vld && !sym_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= F_IDLE;
			seq_q      <= 8'd0;
			crc_q      <= CRC_INIT;
			in_frame_q <= 1'b0;
			held_len_q <= 7'd0;
			pay_cnt_q  <= 7'd0;
			disc_q     <= 1'b0;
			dat_q      <= 1'b0;
			fin_q      <= 1'b0;
		end else if (accept) begin
			st_q       <= first_st;
			dat_q      <= dat_n;
			fin_q      <= fin_n;
			held_len_q <= hl_n;
			pay_cnt_q  <= pc_n + 7'(dat_n);
			in_frame_q <= !last_in_frame;
			disc_q     <= last_in_frame ? 1'b0 : disc_n;
			if (start) begin
				crc_q <= CRC_INIT;
			end
			if (hdr_n) begin
				seq_q <= seq_q + 8'd1;
			end
		end else if (adv) begin
			st_q <= nxt;
			if (crc_upd) begin
				crc_q <= crc_step(crc_q, cur_byte);
			end
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		if (accept) begin
			type_q <= frame_type;
			len_q  <= payload_len;
			data_q <= data_byte;
			seqb_q <= seq_q;
		end
	end

endmodule

### src/ccfe_fifo.sv
// short queue of decoded symbols between front and back
// depends on ccfe_pkg
module ccfe_fifo import ccfe_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  sym_t wr_data,
	output logic q_full,
	input  logic rd_en,
	output sym_t rd_data,
	output logic q_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	sym_t          ent_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr, do_rd;

	assign q_full  = (cnt_q == CW'(DEPTH));
	assign q_empty = (cnt_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_data = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
			end
			if (do_rd) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			ent_q[wp_q] <= wr_data;
		end
	end

endmodule

### src/ccfe_back.sv
// back end: cobs block store, code byte emission, packing into results
// depends on ccfe_pkg
module ccfe_back import ccfe_pkg::*; #(
	parameter int STORE_DEPTH = MAX_PAYLOAD_DEF + STORE_SLACK
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       sym_empty,
	input  sym_t       sym,
	output logic       sym_pop,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte_a,
	output logic [7:0] out_byte_b,
	output logic [7:0] out_byte_c,
	output logic [7:0] out_byte_d,
	output logic [2:0] byte_count,
	output logic       frame_end
);

	localparam int IW = $clog2(STORE_DEPTH);
	localparam int FW = $clog2(STORE_DEPTH + 1);

	typedef enum logic [3:0] {
		B_IDLE  = 4'b0001,
		B_CODE  = 4'b0010,
		B_BODY  = 4'b0100,
		B_DELIM = 4'b1000
	} bst_t;

	logic [7:0]    mem [STORE_DEPTH];
	logic [7:0]    rd_q;
	logic [IW-1:0] rd_addr, idx_q;
	logic          rd_en;

	bst_t          st_q;
	logic [FW-1:0] fill_q;
	logic          fin_q, ie_q, flush_q, end_pend_q;
	logic [7:0]    pk_q [4];
	logic [2:0]    pk_n_q;

	logic          go, emit, take, store, xfer, out_vld_q, out_free, body_last;
	logic [7:0]    emit_byte;

	assign go        = !flush_q && (pk_n_q != 3'd4);
	assign take      = go && (st_q == B_IDLE) && !sym_empty;
	assign store     = take && !sym.fin && (sym.data != 8'h00);
	assign sym_pop   = take;
	assign body_last = (FW'(idx_q) + FW'(1) == fill_q);

	always_comb begin
		emit      = 1'b0;
		emit_byte = 8'h00;
		rd_en     = 1'b0;
		rd_addr   = '0;
		unique case (st_q)
			B_CODE: begin
				emit      = go;
				emit_byte = 8'(fill_q) + 8'd1;
				rd_en     = go;
			end
			B_BODY: begin
				emit      = go;
				emit_byte = rd_q;
				rd_en     = go && !body_last;
				rd_addr   = idx_q + IW'(1);
			end
			B_DELIM: begin
				emit      = go;
				emit_byte = DELIM_BYTE;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign out_free = !out_vld_q || pop;
	assign xfer     = out_free && ((pk_n_q == 3'd4) || (flush_q && (pk_n_q != 3'd0)));

	// block store
	always_ff @(posedge clk) begin
		if (store) begin
			mem[fill_q[IW-1:0]] <= sym.data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// block sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= B_IDLE;
			fill_q     <= '0;
			idx_q      <= '0;
			fin_q      <= 1'b0;
			ie_q       <= 1'b0;
			flush_q    <= 1'b0;
			end_pend_q <= 1'b0;
		end else begin
			if (flush_q && ((pk_n_q == 3'd0) || xfer)) begin
				flush_q <= 1'b0;
			end
			if (xfer) begin
				end_pend_q <= 1'b0;
			end
			unique case (st_q)
				B_IDLE: begin
					if (take) begin
						if (store) begin
							fill_q  <= fill_q + FW'(1);
							flush_q <= sym.item_end;
						end else begin
							fin_q <= sym.fin;
							ie_q  <= sym.item_end;
							st_q  <= B_CODE;
						end
					end
				end
				B_CODE, B_BODY: begin
					if (go) begin
						if ((st_q == B_CODE && fill_q != '0) || (st_q == B_BODY && !body_last)) begin
							idx_q <= (st_q == B_CODE) ? '0 : idx_q + IW'(1);
							st_q  <= B_BODY;
						end else begin
							fill_q <= '0;
							if (fin_q) begin
								st_q <= B_DELIM;
							end else begin
								flush_q <= ie_q;
								st_q    <= B_IDLE;
							end
						end
					end
				end
				B_DELIM: begin
					if (go) begin
						end_pend_q <= 1'b1;
						flush_q    <= 1'b1;
						st_q       <= B_IDLE;
					end
				end
				default: begin
					st_q <= B_IDLE;
				end
			endcase
		end
	end

	// packer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pk_n_q    <= 3'd0;
			out_vld_q <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				pk_q[i] <= 8'h00;
			end
		end else begin
			if (xfer) begin
				out_vld_q <= 1'b1;
				pk_n_q    <= 3'd0;
				for (int i = 0; i < 4; i++) begin
					pk_q[i] <= 8'h00;
				end
			end else begin
				if (pop) begin
					out_vld_q <= 1'b0;
				end
				if (emit) begin
					pk_q[pk_n_q[1:0]] <= emit_byte;
					pk_n_q            <= pk_n_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			out_byte_a <= pk_q[0];
			out_byte_b <= pk_q[1];
			out_byte_c <= pk_q[2];
			out_byte_d <= pk_q[3];
			byte_count <= pk_n_q;
			frame_end  <= end_pend_q;
		end
	end

	assign empty = !out_vld_q;

endmodule

### src/ccfe_checker.sv
// port-level checks on the cobs frame encoder results, bound to the top level
// depends on crc_cobs_frame_encoder_core
module ccfe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [7:0] out_byte_a,
	input logic [7:0] out_byte_b,
	input logic [7:0] out_byte_c,
	input logic [7:0] out_byte_d,
	input logic [2:0] byte_count,
	input logic       frame_end
);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (byte_count != 3'd0 && byte_count <= 3'd4))
		else $error("byte_count out of range");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((byte_count == 3'd4 || out_byte_d == 8'h00) &&
		            (byte_count >= 3'd3 || out_byte_c == 8'h00) &&
		            (byte_count >= 3'd2 || out_byte_b == 8'h00)))
		else $error("unused result byte not zero");

	a_delim_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && frame_end) |-> ((byte_count == 3'd1 && out_byte_a == 8'h00) ||
		                           (byte_count == 3'd2 && out_byte_b == 8'h00) ||
		                           (byte_count == 3'd3 && out_byte_c == 8'h00) ||
		                           (byte_count == 3'd4 && out_byte_d == 8'h00)))
		else $error("frame end without delimiter");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_byte_a) && $stable(byte_count) &&
		                      $stable(frame_end)))
		else $error("waiting result changed");

endmodule

bind crc_cobs_frame_encoder_core ccfe_checker u_ccfe_checker (.*);

### tb/sv/ccfe_wire_checker.sv
`timescale 1ns / 1ps
// request and result monitor for crc_cobs_frame_encoder_core: predicts the wire words
// of every accepted request and compares them with the popped results; no dependencies
module ccfe_wire_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       full,
	input  logic [7:0] frame_type,
	input  logic [6:0] payload_len,
	input  logic [7:0] data_byte,
	input  logic       last_in_frame,
	input  logic       empty,
	input  logic       pop,
	input  logic [7:0] out_byte_a,
	input  logic [7:0] out_byte_b,
	input  logic [7:0] out_byte_c,
	input  logic [7:0] out_byte_d,
	input  logic [2:0] byte_count,
	input  logic       frame_end,
	output int         fail_count,
	output int         pending,
	output int         words_checked
);

	localparam logic [7:0]  START_OF_FRAME = 8'hB2;
	localparam logic [7:0]  FRAME_DELIM    = 8'h00;
	localparam logic [7:0]  BLOCK_LIMIT    = 8'hFF;
	localparam logic [15:0] CRC_SEED       = 16'hFFFF;
	localparam logic [15:0] CRC_GEN        = 16'h1021;
	localparam int          PAYLOAD_MAX    = 64;
	localparam int          BLOCK_DEPTH    = 72;

	typedef struct {
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] c;
		logic [7:0] d;
		logic [2:0] cnt;
		logic       fin;
	} wire_word_t;

	logic [7:0]  seq_next;
	logic [15:0] crc_acc;
	logic [7:0]  blk [0:BLOCK_DEPTH-1];
	int          blk_fill;
	bit          open_frame;
	logic [6:0]  len_held;
	int          pay_seen;
	bit          refuse;
	logic [7:0]  wire_bytes [$];
	wire_word_t  expected_words [$];
	wire_word_t  head;

	function automatic void crc_add(input logic [7:0] b);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb = crc_acc[15] ^ b[i];
			crc_acc = {crc_acc[14:0], 1'b0};
			if (fb) begin
				crc_acc = crc_acc ^ CRC_GEN;
			end
		end
	endfunction

	function automatic void block_close();
		wire_bytes.push_back(8'(blk_fill + 1));
		for (int i = 0; i < blk_fill && i < BLOCK_DEPTH; i++) begin
			wire_bytes.push_back(blk[i]);
		end
		blk_fill = 0;
	endfunction

	function automatic void cobs_add(input logic [7:0] b);
		if (b == FRAME_DELIM) begin
			block_close();
			return;
		end
		if (blk_fill < BLOCK_DEPTH) begin
			blk[blk_fill] = b;
			blk_fill++;
		end
		if (blk_fill + 1 == int'(BLOCK_LIMIT)) begin
			block_close();
		end
	endfunction

	function automatic void predict_words(input logic [7:0] t, input logic [6:0] l,
			input logic [7:0] d, input logic fin);
		logic [7:0]  seq;
		logic [15:0] crc_final;
		bit          ended;
		int          nwords;
		int          n;
		wire_word_t  w;
		ended = 0;
		wire_bytes.delete();
		if (!open_frame) begin
			open_frame = 1;
			len_held = l;
			pay_seen = 0;
			blk_fill = 0;
			crc_acc = CRC_SEED;
			refuse = l > PAYLOAD_MAX;
			if (!refuse) begin
				seq = seq_next;
				seq_next = seq_next + 8'd1;
				cobs_add(START_OF_FRAME);
				crc_add(t);
				cobs_add(t);
				crc_add(seq);
				cobs_add(seq);
				crc_add({1'b0, l});
				cobs_add({1'b0, l});
			end
		end
		if (!refuse && len_held != 0 && pay_seen < PAYLOAD_MAX) begin
			pay_seen++;
			crc_add(d);
			cobs_add(d);
		end
		if (fin) begin
			if (!refuse) begin
				crc_final = crc_acc;
				cobs_add(crc_final[7:0]);
				cobs_add(crc_final[15:8]);
				block_close();
				wire_bytes.push_back(FRAME_DELIM);
				ended = 1;
			end
			open_frame = 0;
			refuse = 0;
			blk_fill = 0;
		end
		nwords = (wire_bytes.size() + 3) / 4;
		for (int k = 0; k < nwords; k++) begin
			n = wire_bytes.size() - 4 * k;
			if (n > 4) begin
				n = 4;
			end
			w.a = wire_bytes[4 * k];
			w.b = (n > 1) ? wire_bytes[4 * k + 1] : 8'h00;
			w.c = (n > 2) ? wire_bytes[4 * k + 2] : 8'h00;
			w.d = (n > 3) ? wire_bytes[4 * k + 3] : 8'h00;
			w.cnt = 3'(n);
			w.fin = ended && (k == nwords - 1);
			expected_words.push_back(w);
		end
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%02h, got 0x%02h", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_next = 8'h00;
			crc_acc = CRC_SEED;
			blk_fill = 0;
			open_frame = 0;
			len_held = 7'd0;
			pay_seen = 0;
			refuse = 0;
			expected_words.delete();
			fail_count = 0;
			words_checked = 0;
			pending = 0;
		end else begin
			if (pop && !empty) begin
				if (expected_words.size() == 0) begin
					$error("result popped with no request waiting for it");
					fail_count++;
				end else begin
					head = expected_words.pop_front();
					check_field("out_byte_a", head.a, out_byte_a);
					check_field("out_byte_b", head.b, out_byte_b);
					check_field("out_byte_c", head.c, out_byte_c);
					check_field("out_byte_d", head.d, out_byte_d);
					check_field("byte_count", {5'd0, head.cnt}, {5'd0, byte_count});
					check_field("frame_end", {7'd0, head.fin}, {7'd0, frame_end});
					words_checked++;
				end
			end
			if (push && !full) begin
				predict_words(frame_type, payload_len, data_byte, last_in_frame);
			end
			pending = expected_words.size();
		end
	end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// top of the crc_cobs_frame_encoder_core test: clock, reset, frame stimulus and verdict
// depends on crc_cobs_frame_encoder_core and ccfe_wire_checker
module testbench;

	localparam int CYCLE_LIMIT = 400000;

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [7:0] frame_type;
	logic [6:0] payload_len;
	logic [7:0] data_byte;
	logic       last_in_frame;
	logic       empty;
	logic       pop;
	logic [7:0] out_byte_a;
	logic [7:0] out_byte_b;
	logic [7:0] out_byte_c;
	logic [7:0] out_byte_d;
	logic [2:0] byte_count;
	logic       frame_end;

	int fail_count;
	int pending;
	int words_checked;
	int tx_idle;
	int rx_idle;
	int requests_sent;
	int frames_sent;
	int cycle_count;

	crc_cobs_frame_encoder_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.frame_type(frame_type),
		.payload_len(payload_len),
		.data_byte(data_byte),
		.last_in_frame(last_in_frame),
		.empty(empty),
		.pop(pop),
		.out_byte_a(out_byte_a),
		.out_byte_b(out_byte_b),
		.out_byte_c(out_byte_c),
		.out_byte_d(out_byte_d),
		.byte_count(byte_count),
		.frame_end(frame_end)
	);

	ccfe_wire_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.frame_type(frame_type),
		.payload_len(payload_len),
		.data_byte(data_byte),
		.last_in_frame(last_in_frame),
		.empty(empty),
		.pop(pop),
		.out_byte_a(out_byte_a),
		.out_byte_b(out_byte_b),
		.out_byte_c(out_byte_c),
		.out_byte_d(out_byte_d),
		.byte_count(byte_count),
		.frame_end(frame_end),
		.fail_count(fail_count),
		.pending(pending),
		.words_checked(words_checked)
	);

	initial begin
		clk = 1'b0;
	end

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("crc_cobs_frame_encoder_core test failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		pop <= arst_n && ($urandom_range(99) >= rx_idle);
	end

	task automatic send_request(input logic [7:0] t, input logic [6:0] l,
			input logic [7:0] d, input logic fin);
		while ($urandom_range(99) < tx_idle) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		frame_type <= t;
		payload_len <= l;
		data_byte <= d;
		last_in_frame <= fin;
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
		@(negedge clk);
		requests_sent++;
		if (fin) begin
			frames_sent++;
		end
	endtask

	function automatic logic [7:0] pick_payload_byte();
		int r;
		r = $urandom_range(99);
		if (r < 25) begin
			return 8'h00;
		end
		if (r < 35) begin
			return 8'hFF;
		end
		return 8'($urandom_range(255));
	endfunction

	// header fields on later requests of a frame are noise the block must ignore
	task automatic send_frame(input logic [7:0] t, input logic [6:0] l, input int n);
		for (int i = 0; i < n; i++) begin
			send_request((i == 0) ? t : 8'($urandom), (i == 0) ? l : 7'($urandom),
				pick_payload_byte(), i == n - 1);
		end
	endtask

	task automatic run_frames(input int budget);
		int start;
		int r;
		int l;
		int n;
		start = requests_sent;
		while (requests_sent - start < budget) begin
			r = $urandom_range(99);
			if (r < 4) begin
				l = $urandom_range(65, 127);
				n = $urandom_range(1, 3);
			end else if (r < 7) begin
				l = $urandom_range(60, 64);
				n = l + $urandom_range(0, 3);
			end else if (r < 17) begin
				l = $urandom_range(0, 12);
				n = $urandom_range(1, 12);
			end else if (r < 25) begin
				l = 0;
				n = 1;
			end else begin
				l = $urandom_range(1, 10);
				n = l;
			end
			send_frame(8'($urandom), 7'(l), n);
		end
	endtask

	task automatic drain_results();
		push <= 1'b0;
		@(negedge clk);
		while (pending != 0) begin
			@(negedge clk);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		frame_type = 8'h00;
		payload_len = 7'd0;
		data_byte = 8'h00;
		last_in_frame = 1'b0;
		pop = 1'b0;
		tx_idle = 11;
		rx_idle = 48;
		requests_sent = 0;
		frames_sent = 0;
		cycle_count = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty frames, data ignored
		send_request(8'h00, 7'd0, 8'h00, 1'b1);
		send_request(8'hFF, 7'd0, 8'hAB, 1'b0);
		send_request(8'h3C, 7'd99, 8'h55, 1'b1);
		// zero and all-ones payload bytes
		send_request(8'h5A, 7'd3, 8'h00, 1'b0);
		send_request(8'h11, 7'd5, 8'hFF, 1'b0);
		send_request(8'h22, 7'd7, 8'h01, 1'b1);
		// over-length frames are refused whole
		send_request(8'hA5, 7'd65, 8'h12, 1'b0);
		send_request(8'hA5, 7'd1, 8'h00, 1'b1);
		send_request(8'h7E, 7'd127, 8'hFF, 1'b1);
		// short frames keep the header length
		send_request(8'h81, 7'd10, 8'h80, 1'b0);
		send_request(8'h81, 7'd10, 8'h7F, 1'b1);
		send_request(8'hC3, 7'd64, 8'h00, 1'b1);
		send_request(8'h01, 7'd2, 8'h00, 1'b0);
		send_request(8'h01, 7'd2, 8'h00, 1'b1);
		// more payload than the header announces
		send_request(8'hF0, 7'd1, 8'hAA, 1'b0);
		send_request(8'h0F, 7'd42, 8'h55, 1'b0);
		send_request(8'hF0, 7'd1, 8'h00, 1'b1);

		run_frames(30);
		drain_results();

		tx_idle = 48;
		rx_idle = 11;
		run_frames(30);

		tx_idle = 0;
		rx_idle = 0;
		// payload past the maximum is dropped
		send_frame(8'hE7, 7'd64, 67);
		run_frames(15);

		drain_results();
		repeat (200) @(negedge clk);

		$display("%0d requests in %0d frames, %0d result words checked, %0d mismatches",
			requests_sent, frames_sent, words_checked, fail_count);
		$display("covered empty, refused, short and overlong frames under both stall patterns");
		if (fail_count == 0) begin
			$display("crc_cobs_frame_encoder_core test passed");
		end else begin
			$display("crc_cobs_frame_encoder_core test failed");
		end
		$finish;
	end

endmodule
